// ===== hw/rtl/acoustic_wave_fd_step_assert.svh =====
// assertion macros for the acoustic wave stencil block
// needs clk and rst_n in the scope of the user
`ifndef ACOUSTIC_WAVE_FD_STEP_ASSERT_SVH
`define ACOUSTIC_WAVE_FD_STEP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define AWFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define AWFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/awfd_pkg.sv =====
// shared types and constants of the acoustic wave stencil block
// no dependencies
package awfd_pkg;

  localparam int MAX_DEPTH   = 1024;
  localparam int SAMPLE_BITS = 24;
  localparam int ROW_W       = $clog2(MAX_DEPTH);
  localparam int DEPTH_W     = 11;
  localparam int COL_W       = 13;
  localparam int CS_AW       = ROW_W + 2;
  localparam int DL_AW       = ROW_W + 1;
  localparam int VEL_W       = 16;
  localparam int COEF_W      = 24;
  localparam int C0_W        = COEF_W + 4;
  localparam int OPND_W      = SAMPLE_BITS + 2;
  localparam int PROD_W      = C0_W + OPND_W;
  localparam int ACC_W       = PROD_W + 3;
  localparam int LAP_W       = ACC_W - 20;
  localparam int TPROD_W     = LAP_W + VEL_W + 1;
  localparam int TERM_W      = TPROD_W - 16;
  localparam int RES_W       = TERM_W + 3;
  localparam int CFG_IW      = 3;
  localparam int CFG_DW      = 24;
  localparam int WIDTH_LIMIT = 4096;
  localparam int DEPTH_LOW   = 5;
  localparam int COUNT_MAX   = 8191;
  localparam int NUM_READS   = 8;
  localparam int NUM_TERMS   = 5;

  typedef enum logic [CFG_IW-1:0] {
    REG_GRID_DEPTH  = 3'd0,
    REG_GRID_WIDTH  = 3'd1,
    REG_COEF_Z_NEAR = 3'd2,
    REG_COEF_Z_FAR  = 3'd3,
    REG_COEF_X_NEAR = 3'd4,
    REG_COEF_X_FAR  = 3'd5
  } reg_idx_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_MAC   = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_VMUL  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic [2:0] rd_idx;
    logic       cap_en;
    logic [2:0] cap_idx;
    logic       mul_en;
    logic [2:0] mul_idx;
    logic       acc_en;
    logic       round_en;
    logic       vmul_en;
    logic       fin_en;
  } cmd_t;

  typedef struct packed {
    logic calc;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/awfd_if.sv =====
// channel interfaces of the acoustic wave stencil block
// depends on awfd_pkg
interface awfd_in_if import awfd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] pres_now;
  logic signed [SAMPLE_BITS-1:0] pres_prev;
  logic [VEL_W-1:0]              vel_term;
  logic                          frame_start;
  logic                          drain;
  modport source (output valid, pres_now, pres_prev, vel_term, frame_start, drain,
                  input ready);
  modport sink (input valid, pres_now, pres_prev, vel_term, frame_start, drain,
                output ready);
endinterface

interface awfd_out_if import awfd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] pres_next;
  logic                          edge_point;
  logic                          frame_last;
  modport source (output valid, pres_next, edge_point, frame_last, input ready);
  modport sink (input valid, pres_next, edge_point, frame_last, output ready);
endinterface

interface awfd_cfg_if import awfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/awfd_ram.sv =====
// generic ram, one write port and one registered read port
// no dependencies
module awfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/awfd_ctrl.sv =====
// sequencer of the acoustic wave stencil block
// depends on awfd_pkg
module awfd_ctrl import awfd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
          step_nxt  = '0;
        end
      end
      ST_READ: begin
        cmd.rd_en   = (step_r < 4'(NUM_READS));
        cmd.rd_idx  = step_r[2:0];
        cmd.cap_en  = (step_r != '0);
        cmd.cap_idx = 3'(step_r - 4'd1);
        step_nxt    = step_r + 4'd1;
        if (step_r == 4'(NUM_READS)) begin
          step_nxt  = '0;
          state_nxt = stat.calc ? ST_MAC : ST_FIN;
        end
      end
      ST_MAC: begin
        cmd.mul_en  = (step_r < 4'(NUM_TERMS));
        cmd.mul_idx = step_r[2:0];
        cmd.acc_en  = (step_r != '0);
        step_nxt    = step_r + 4'd1;
        if (step_r == 4'(NUM_TERMS)) begin
          step_nxt  = '0;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        state_nxt    = ST_VMUL;
      end
      ST_VMUL: begin
        cmd.vmul_en = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.fin_en = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ===== hw/rtl/awfd_dp.sv =====
// datapath of the acoustic wave stencil block: stores, counters, mac, rounding
// depends on awfd_pkg and awfd_ram
module awfd_dp import awfd_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  output stat_t                         stat,
  input  logic signed [SAMPLE_BITS-1:0] in_pres_now,
  input  logic signed [SAMPLE_BITS-1:0] in_pres_prev,
  input  logic [VEL_W-1:0]              in_vel_term,
  input  logic                          in_frame_start,
  input  logic                          in_drain,
  input  logic                          cfg_we,
  input  logic [CFG_IW-1:0]             cfg_index,
  input  logic [CFG_DW-1:0]             cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_pres_next,
  output logic                          out_edge_point,
  output logic                          out_frame_last
);

  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'((1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - RES_W'(1);

  // configuration
  logic [DEPTH_W-1:0]       grid_depth_r;
  logic [COL_W-1:0]         grid_width_r;
  logic signed [COEF_W-1:0] czn_r, czf_r, cxn_r, cxf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_depth_r <= DEPTH_W'(64);
      grid_width_r <= COL_W'(64);
      czn_r        <= '0;
      czf_r        <= '0;
      cxn_r        <= '0;
      cxf_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_DEPTH:  grid_depth_r <= cfg_data[DEPTH_W-1:0];
        REG_GRID_WIDTH:  grid_width_r <= cfg_data[COL_W-1:0];
        REG_COEF_Z_NEAR: czn_r <= cfg_data;
        REG_COEF_Z_FAR:  czf_r <= cfg_data;
        REG_COEF_X_NEAR: cxn_r <= cfg_data;
        REG_COEF_X_FAR:  cxf_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // position counters
  logic [COL_W-1:0] col_cnt_r;
  logic [ROW_W-1:0] row_cnt_r;

  // latched item
  logic [COL_W-1:0]              pc_r;
  logic [ROW_W-1:0]              pr_r;
  logic [DEPTH_W-1:0]            depth_r;
  logic signed [SAMPLE_BITS-1:0] now_r, prev_r;
  logic [VEL_W-1:0]              vel_r;
  logic                          emit_r, edge_r, last_r;
  logic signed [C0_W-1:0]        c0_r;

  logic [DEPTH_W-1:0] depth_c;
  logic [COL_W-1:0]   width_c, c_c, m_c;
  logic [ROW_W-1:0]   r_c;
  logic               emit_c, edge_c, last_c;

  always_comb begin
    depth_c = grid_depth_r;
    if (grid_depth_r < DEPTH_W'(DEPTH_LOW)) depth_c = DEPTH_W'(DEPTH_LOW);
    if (grid_depth_r > DEPTH_W'(MAX_DEPTH)) depth_c = DEPTH_W'(MAX_DEPTH);
    width_c = grid_width_r;
    if (grid_width_r < COL_W'(DEPTH_LOW))   width_c = COL_W'(DEPTH_LOW);
    if (grid_width_r > COL_W'(WIDTH_LIMIT)) width_c = COL_W'(WIDTH_LIMIT);
    c_c    = in_frame_start ? '0 : col_cnt_r;
    r_c    = in_frame_start ? '0 : row_cnt_r;
    m_c    = c_c - COL_W'(2);
    emit_c = (c_c >= COL_W'(2)) && (m_c < width_c);
    edge_c = (r_c < ROW_W'(2)) || ({1'b0, r_c} + DEPTH_W'(2) >= depth_c)
          || (m_c < COL_W'(2)) || ({1'b0, m_c} + 14'd2 >= {1'b0, width_c});
    last_c = (m_c == width_c - COL_W'(1)) && ({1'b0, r_c} == depth_c - DEPTH_W'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pc_r    <= c_c;
      pr_r    <= r_c;
      depth_r <= depth_c;
      emit_r  <= emit_c;
      edge_r  <= edge_c;
      last_r  <= last_c;
      now_r   <= in_drain ? '0 : in_pres_now;
      prev_r  <= in_drain ? '0 : in_pres_prev;
      vel_r   <= in_drain ? '0 : in_vel_term;
      c0_r    <= -(C0_W'(czn_r) + C0_W'(czf_r) + C0_W'(cxn_r) + C0_W'(cxf_r)) <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (cmd.fin_en) begin
      if ({1'b0, pr_r} + DEPTH_W'(1) >= depth_r) begin
        row_cnt_r <= '0;
        col_cnt_r <= (pc_r < COL_W'(COUNT_MAX)) ? pc_r + COL_W'(1) : pc_r;
      end else begin
        row_cnt_r <= pr_r + ROW_W'(1);
        col_cnt_r <= pc_r;
      end
    end
  end

  // stores
  logic [1:0]             slot;
  logic [ROW_W-1:0]       row;
  logic [SAMPLE_BITS-1:0] cs_rdata, pd_rdata;
  logic [VEL_W-1:0]       vd_rdata;

  always_comb begin
    slot = pc_r[1:0] + 2'd2;
    row  = pr_r;
    case (cmd.rd_idx)
      3'd0: row = pr_r - ROW_W'(2);
      3'd1: row = pr_r - ROW_W'(1);
      3'd3: row = pr_r + ROW_W'(1);
      3'd4: row = pr_r + ROW_W'(2);
      3'd5: slot = pc_r[1:0] + 2'd3;
      3'd6: slot = pc_r[1:0] + 2'd1;
      3'd7: slot = pc_r[1:0];
      default: ;
    endcase
  end

  awfd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(4 * MAX_DEPTH)) u_col_store (
    .clk(clk), .we(cmd.fin_en), .waddr({pc_r[1:0], pr_r}), .wdata(now_r),
    .re(cmd.rd_en), .raddr({slot, row}), .rdata(cs_rdata)
  );

  awfd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(2 * MAX_DEPTH)) u_prev_delay (
    .clk(clk), .we(cmd.fin_en), .waddr({pc_r[0], pr_r}), .wdata(prev_r),
    .re(cmd.rd_en && cmd.rd_idx == 3'd0), .raddr({pc_r[0], pr_r}), .rdata(pd_rdata)
  );

  awfd_ram #(.WIDTH(VEL_W), .DEPTH(2 * MAX_DEPTH)) u_vel_delay (
    .clk(clk), .we(cmd.fin_en), .waddr({pc_r[0], pr_r}), .wdata(vel_r),
    .re(cmd.rd_en && cmd.rd_idx == 3'd0), .raddr({pc_r[0], pr_r}), .rdata(vd_rdata)
  );

  logic signed [SAMPLE_BITS-1:0] samp_r [NUM_READS];

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      samp_r[cmd.cap_idx] <= cs_rdata;
    end
  end

  // multiply and accumulate
  logic signed [C0_W-1:0]    coef_m;
  logic signed [OPND_W-1:0]  opnd_m;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [LAP_W-1:0]   lap_r;
  logic signed [TPROD_W-1:0] tprod_r;

  always_comb begin
    coef_m = c0_r;
    opnd_m = OPND_W'(samp_r[2]);
    case (cmd.mul_idx)
      3'd1: begin
        coef_m = C0_W'(czn_r);
        opnd_m = OPND_W'(samp_r[1]) + OPND_W'(samp_r[3]);
      end
      3'd2: begin
        coef_m = C0_W'(czf_r);
        opnd_m = OPND_W'(samp_r[0]) + OPND_W'(samp_r[4]);
      end
      3'd3: begin
        coef_m = C0_W'(cxn_r);
        opnd_m = OPND_W'(samp_r[5]) + OPND_W'(samp_r[6]);
      end
      3'd4: begin
        coef_m = C0_W'(cxf_r);
        opnd_m = OPND_W'(samp_r[7]) + OPND_W'(now_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (cmd.mul_en) begin
      prod_r <= coef_m * opnd_m;
    end
    if (cmd.round_en) begin
      lap_r <= LAP_W'((acc_r + ACC_W'(1 << 19)) >>> 20);
    end
    if (cmd.vmul_en) begin
      tprod_r <= TPROD_W'($signed({1'b0, vd_rdata})) * TPROD_W'(lap_r);
    end
  end

  // final update and saturation
  logic signed [TERM_W-1:0] term;
  logic signed [RES_W-1:0]  sum;
  logic signed [SAMPLE_BITS-1:0] res;

  always_comb begin
    term = TERM_W'((tprod_r + TPROD_W'(1 << 15)) >>> 16);
    sum  = (RES_W'(samp_r[2]) <<< 1) - RES_W'($signed(pd_rdata)) + RES_W'(term);
    if (sum > SAT_HI) begin
      res = SAT_HI[SAMPLE_BITS-1:0];
    end else if (sum < SAT_LO) begin
      res = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      res = sum[SAMPLE_BITS-1:0];
    end
    if (edge_r) begin
      res = pd_rdata;
    end
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin_en && emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_en && emit_r) begin
      out_pres_next  <= res;
      out_edge_point <= edge_r;
      out_frame_last <= last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.calc     = emit_r && !edge_r;
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

// ===== hw/rtl/acoustic_wave_fd_step.sv =====
// 4th-order 2-d acoustic wave stencil step, top level
// depends on awfd_pkg, awfd_if, awfd_ctrl and awfd_dp
// each item is accepted, read eight times, then for an interior item multiply-accumulated, rounded,
// scaled by velocity and finished once the output is free; a border item or one without a result goes
// from the reads straight to the finish; one item at a time, paced by the eight reads through the single
// read port of the column store and the five-term multiply-accumulate on one shared multiplier
// synchronous active-low rst_n resets sequencer, counters, configuration and output valid, not other data or stores
`include "acoustic_wave_fd_step_assert.svh"
module acoustic_wave_fd_step import awfd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  awfd_in_if.sink  in_ch,
  awfd_out_if.source out_ch,
  awfd_cfg_if.sink cfg_ch
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ch.ready = 1'b1;

  awfd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  awfd_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_pres_now(in_ch.pres_now), .in_pres_prev(in_ch.pres_prev),
    .in_vel_term(in_ch.vel_term), .in_frame_start(in_ch.frame_start),
    .in_drain(in_ch.drain),
    .cfg_we(cfg_ch.valid && cfg_ch.ready), .cfg_index(cfg_ch.index),
    .cfg_data(cfg_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_pres_next(out_ch.pres_next), .out_edge_point(out_ch.edge_point),
    .out_frame_last(out_ch.frame_last)
  );

  `AWFD_ASSERT_NEXT(a_one_item_at_a_time, in_ch.valid && in_ch.ready, !in_ch.ready)
  `AWFD_ASSERT_NOW(a_single_phase, 1'b1, $onehot0({cmd.load, cmd.rd_en, cmd.mul_en, cmd.round_en, cmd.vmul_en, cmd.fin_en}))
  `AWFD_ASSERT_NOW(a_no_result_overrun, cmd.fin_en, !out_ch.valid || out_ch.ready)

endmodule
